// ===== design/lci_pkg.sv =====
// ----------------------------------------------------------------------------
// lci_pkg
// Types, constants and codes shared by the level crossing interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lci_pkg;

    localparam int MAX_SAMPLES     = 65536;
    localparam int LCI_QUEUE_DEPTH = 4;

    localparam logic [15:0] IDX_LIMIT =
        16'((MAX_SAMPLES - 1 > 65535) ? 65535 : MAX_SAMPLES - 1);

    // register indexes of the configuration port
    localparam logic [1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_DETECT_RISING = 2'd1;
    localparam logic [1:0] CFG_RANGE_START   = 2'd2;
    localparam logic [1:0] CFG_RANGE_END     = 2'd3;

    // divider: 65-bit numerator magnitude shifted by 16 fraction bits
    localparam int NUM_W = 65;
    localparam int DVD_W = NUM_W + 16;
    localparam int CNT_W = $clog2(DVD_W);

    localparam logic [48:0] Q_CAP     = 49'h1_0000_0000_0000;
    localparam logic [48:0] POS_MAX_Q = 49'h0_7FFF_FFFF_FFFF;
    localparam logic [48:0] NEG_MAG_Q = 49'h0_8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] threshold;
        logic               detect_rising;
        logic        [15:0] range_start;
        logic        [15:0] range_end;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic        [15:0] idx;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL_A,
        BK_MUL_B,
        BK_SUM,
        BK_DIV,
        BK_FIN,
        BK_OUT
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/lci_fifo.sv =====
// ----------------------------------------------------------------------------
// lci_fifo
// Small register queue carrying crossing jobs from the front to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 144
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [WIDTH-1:0]            i_push_data,
    input  wire logic                        i_pop,
    output logic      [WIDTH-1:0]            o_head,
    output lci_pkg::t_fifo_status            o_status
);
    import lci_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W_Q-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ===== design/lci_front.sv =====
// ----------------------------------------------------------------------------
// lci_front
// Sample indexing, above/below tracking and crossing classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  lci_pkg::t_cfg             i_cfg,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [31:0]   i_x_coord,
    input  wire logic signed [31:0]   i_y_sample,
    input  wire logic                 i_first_sample,
    input  lci_pkg::t_fifo_status     i_fifo_status,
    output logic                      o_push,
    output lci_pkg::t_job             o_job
);
    import lci_pkg::*;

    logic               r_above, n_above;
    logic signed [31:0] r_prev_x, n_prev_x;
    logic signed [31:0] r_prev_y, n_prev_y;
    logic        [15:0] r_count, n_count;
    logic               r_past_end, n_past_end;

    logic        accept;
    logic        skip;
    logic [15:0] idx;
    logic        in_range;
    logic        flip;

    assign o_in_ready = !i_fifo_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign skip       = !i_first_sample && r_past_end;
    assign idx        = i_first_sample ? 16'd0 : r_count;
    assign in_range   = (i_cfg.range_start <= i_cfg.range_end) &&
                        (idx >= i_cfg.range_start) && (idx <= i_cfg.range_end);
    assign flip       = r_above ? (i_y_sample < i_cfg.threshold)
                                : (i_y_sample > i_cfg.threshold);

    always_comb begin
        n_above    = r_above;
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_count    = r_count;
        n_past_end = r_past_end;
        o_push     = 1'b0;
        if (accept && !skip) begin
            n_past_end = (idx >= IDX_LIMIT);
            if (idx < IDX_LIMIT) begin
                n_count = idx + 16'd1;
            end
            if (in_range) begin
                if (idx == i_cfg.range_start) begin
                    n_above = (i_y_sample > i_cfg.threshold);
                end else if (flip) begin
                    n_above = !r_above;
                    o_push  = ((!r_above) == i_cfg.detect_rising);
                end
            end
            n_prev_x = i_x_coord;
            n_prev_y = i_y_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above    <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_count    <= '0;
            r_past_end <= 1'b0;
        end else begin
            r_above    <= n_above;
            r_prev_x   <= n_prev_x;
            r_prev_y   <= n_prev_y;
            r_count    <= n_count;
            r_past_end <= n_past_end;
        end
    end

    assign o_job.x0  = r_prev_x;
    assign o_job.y0  = r_prev_y;
    assign o_job.x1  = i_x_coord;
    assign o_job.y1  = i_y_sample;
    assign o_job.idx = idx;

endmodule

`default_nettype wire

// ===== design/lci_back.sv =====
// ----------------------------------------------------------------------------
// lci_back
// Crossing interpolation: shared 32x32 multiplier, then a bit-serial
// restoring divider with saturation, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic signed [31:0]   i_threshold,
    input  lci_pkg::t_job             i_head,
    input  lci_pkg::t_fifo_status     i_fifo_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic             [15:0]   o_crossing_index,
    output logic signed      [31:0]   o_crossing_value,
    output logic signed      [47:0]   o_crossing_position
);
    import lci_pkg::*;

    t_back_state r_state, n_state;

    logic ld_prep, ld_p1, ld_p2, ld_sum, div_step, ld_out;

    t_job               r_job;
    logic        [31:0] r_ma, r_mb, r_md, r_mx0;
    logic               r_sab, r_sxd, r_dneg, r_eq;
    logic signed [32:0] r_half;
    logic        [63:0] r_p1, r_p2;
    logic               r_nneg;
    logic [DVD_W-1:0]   r_dvd;
    logic        [31:0] r_rem;
    logic        [48:0] r_q;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic        [15:0] r_idx_o;
    logic signed [31:0] r_val_o;
    logic signed [47:0] r_pos_o;

    // operand preparation
    logic signed [32:0] a_w, b_w, d_w, h_w;
    assign a_w = $signed({i_threshold[31], i_threshold}) - $signed({r_job.y0[31], r_job.y0});
    assign b_w = $signed({r_job.x1[31], r_job.x1}) - $signed({r_job.x0[31], r_job.x0});
    assign d_w = $signed({r_job.y1[31], r_job.y1}) - $signed({r_job.y0[31], r_job.y0});
    assign h_w = $signed({r_job.x0[31], r_job.x0}) + $signed({r_job.x1[31], r_job.x1});

    // shared multiplier
    logic [31:0] mop_a, mop_b;
    logic [63:0] prod;
    assign mop_a = (r_state == BK_MUL_A) ? r_ma : r_mx0;
    assign mop_b = (r_state == BK_MUL_A) ? r_mb : r_md;
    assign prod  = mop_a * mop_b;

    // signed numerator sum
    logic signed [65:0] s1, s2, num;
    logic        [64:0] num_mag;
    assign s1      = r_sab ? -$signed({2'b00, r_p1}) : $signed({2'b00, r_p1});
    assign s2      = r_sxd ? -$signed({2'b00, r_p2}) : $signed({2'b00, r_p2});
    assign num     = s1 + s2;
    assign num_mag = num[65] ? 65'(-num) : num[64:0];

    // divider step
    logic [32:0] r_t;
    logic        ge;
    logic [31:0] rem_n;
    logic [49:0] q_n;
    assign r_t   = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = (r_t >= {1'b0, r_md});
    assign rem_n = ge ? 32'(r_t - {1'b0, r_md}) : r_t[31:0];
    assign q_n   = {r_q, ge};

    // final clamp
    logic        [48:0] qm, qc;
    logic               rneg;
    logic signed [47:0] pos_w;
    always_comb begin
        qm   = r_sat ? Q_CAP : r_q;
        rneg = r_nneg ^ r_dneg;
        if (rneg) begin
            qc = (qm > NEG_MAG_Q) ? NEG_MAG_Q : qm;
        end else begin
            qc = (qm > POS_MAX_Q) ? POS_MAX_Q : qm;
        end
        if (r_eq) begin
            pos_w = {r_half, 15'd0};
        end else if (rneg) begin
            pos_w = 48'(49'd0 - qc);
        end else begin
            pos_w = qc[47:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (!i_fifo_status.empty) n_state = BK_PREP;
            BK_PREP:  n_state = (r_job.y0 == r_job.y1) ? BK_FIN : BK_MUL_A;
            BK_MUL_A: n_state = BK_MUL_B;
            BK_MUL_B: n_state = BK_SUM;
            BK_SUM:   n_state = BK_DIV;
            BK_DIV:   if (r_cnt == '0) n_state = BK_FIN;
            BK_FIN:   n_state = BK_OUT;
            BK_OUT:   if (i_out_ready) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        ld_prep     = 1'b0;
        ld_p1       = 1'b0;
        ld_p2       = 1'b0;
        ld_sum      = 1'b0;
        div_step    = 1'b0;
        ld_out      = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            BK_IDLE:  o_pop       = !i_fifo_status.empty;
            BK_PREP:  ld_prep     = 1'b1;
            BK_MUL_A: ld_p1       = 1'b1;
            BK_MUL_B: ld_p2       = 1'b1;
            BK_SUM:   ld_sum      = 1'b1;
            BK_DIV:   div_step    = 1'b1;
            BK_FIN:   ld_out      = 1'b1;
            BK_OUT:   o_out_valid = 1'b1;
            default:  o_pop       = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (ld_prep) begin
            r_ma   <= a_w[32] ? 32'(-a_w) : a_w[31:0];
            r_mb   <= b_w[32] ? 32'(-b_w) : b_w[31:0];
            r_md   <= d_w[32] ? 32'(-d_w) : d_w[31:0];
            r_mx0  <= r_job.x0[31] ? 32'(-$signed({r_job.x0[31], r_job.x0}))
                                   : r_job.x0[31:0];
            r_sab  <= a_w[32] ^ b_w[32];
            r_sxd  <= r_job.x0[31] ^ d_w[32];
            r_dneg <= d_w[32];
            r_eq   <= (r_job.y0 == r_job.y1);
            r_half <= h_w;
        end
        if (ld_p1) begin
            r_p1 <= prod;
        end
        if (ld_p2) begin
            r_p2 <= prod;
        end
        if (ld_sum) begin
            r_nneg <= num[65];
            r_dvd  <= {num_mag, 16'd0};
            r_rem  <= '0;
            r_q    <= '0;
            r_sat  <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W - 1);
        end
        if (div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= rem_n;
            r_q   <= q_n[48:0];
            r_sat <= r_sat || (q_n > {1'b0, Q_CAP});
            r_cnt <= r_cnt - 1'b1;
        end
        if (ld_out) begin
            r_idx_o <= r_job.idx;
            r_val_o <= r_job.y1;
            r_pos_o <= pos_w;
        end
    end

    assign o_crossing_index    = r_idx_o;
    assign o_crossing_value    = r_val_o;
    assign o_crossing_position = r_pos_o;

endmodule

`default_nettype wire

// ===== design/level_crossing_interpolator.sv =====
// ----------------------------------------------------------------------------
// level_crossing_interpolator
// Threshold crossing detector with linear interpolation of the crossing x.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one (x, y, first) sample per
// transfer. The front end classifies each sample in the cycle it is taken
// and sustains one sample per cycle as long as the job queue has room.
// Output channel (o_out_valid / i_out_ready): one transfer per crossing in
// the selected direction, in sample order.
// Each crossing goes through the queue (QUEUE_DEPTH entries) to the back
// end, which pops it, sets up the operands, forms two products on one
// 32x32 multiplier, sums them, runs a one-bit-per-cycle divider, loads the
// output register and raises o_out_valid. Equal y values skip the products,
// sum and divider. The back end works on one crossing at a time and holds
// it until it is transferred, so a stalled receiver fills the queue and
// then drops o_in_ready; samples without a crossing never touch the back
// end. Configuration writes (i_cfg_we) take effect on the next edge and
// must be made by the user while no crossing is pending; the block does
// not enforce this. Reset empties the queue, clears the sample state and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module level_crossing_interpolator #(
    parameter int QUEUE_DEPTH = lci_pkg::LCI_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic        [1:0]    i_cfg_index,
    input  wire logic        [31:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [31:0]   i_x_coord,
    input  wire logic signed [31:0]   i_y_sample,
    input  wire logic                 i_first_sample,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic             [15:0]   o_crossing_index,
    output logic signed      [31:0]   o_crossing_value,
    output logic signed      [47:0]   o_crossing_position
);
    import lci_pkg::*;

    t_cfg         r_cfg;
    t_fifo_status fifo_status;
    t_job         push_job;
    t_job         head_job;
    logic         push;
    logic         pop;
    logic [$bits(t_job)-1:0] head_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= '0;
            r_cfg.detect_rising <= 1'b1;
            r_cfg.range_start   <= '0;
            r_cfg.range_end     <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD:     r_cfg.threshold     <= $signed(i_cfg_data);
                CFG_DETECT_RISING: r_cfg.detect_rising <= i_cfg_data[0];
                CFG_RANGE_START:   r_cfg.range_start   <= i_cfg_data[15:0];
                CFG_RANGE_END:     r_cfg.range_end     <= i_cfg_data[15:0];
                default:           r_cfg.range_end     <= r_cfg.range_end;
            endcase
        end
    end

    lci_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_x_coord      (i_x_coord),
        .i_y_sample     (i_y_sample),
        .i_first_sample (i_first_sample),
        .i_fifo_status  (fifo_status),
        .o_push         (push),
        .o_job          (push_job)
    );

    lci_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_job))
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_job),
        .i_pop       (pop),
        .o_head      (head_bits),
        .o_status    (fifo_status)
    );

    assign head_job = head_bits;

    lci_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_threshold         (r_cfg.threshold),
        .i_head              (head_job),
        .i_fifo_status       (fifo_status),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_crossing_index    (o_crossing_index),
        .o_crossing_value    (o_crossing_value),
        .o_crossing_position (o_crossing_position)
    );

endmodule

`default_nettype wire

// ===== design/lci_checker.sv =====
// ----------------------------------------------------------------------------
// lci_checker
// Port-level checks of the level crossing interpolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lci_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic        [15:0]   o_crossing_index,
    input wire logic signed [31:0]   o_crossing_value,
    input wire logic signed [47:0]   o_crossing_position
);

    // a result stays offered until it is transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_crossing_index) &&
            $stable(o_crossing_value) && $stable(o_crossing_position))
        else $error("result payload changed while stalled");

    // reset leaves no result pending and the input ready
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // the back end returns to idle after each transfer, so results never abut
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("back-to-back results");

endmodule

bind level_crossing_interpolator lci_checker u_lci_checker (.*);

`default_nettype wire
